/* design/code_lock_controller_defines.svh */
// Assertion macros shared by the code lock checker.
`ifndef CODE_LOCK_CONTROLLER_DEFINES_SVH
`define CODE_LOCK_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("code lock check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("code lock check failed");

`endif

/* design/clc_pkg.sv */
// Types, constants and helpers for the code lock controller.
package clc_pkg;

  localparam int unsigned CODE_LEN_DEF = 8;
  localparam int unsigned TICK_W       = 16;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned NUM_BTN      = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_TICKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TICKS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS   = 8'd3;

  localparam logic [TICK_W-1:0] FILTER_TICKS_RST = 16'd200;
  localparam logic [TICK_W-1:0] HOLD_TICKS_RST   = 16'd3000;
  localparam logic [TICK_W-1:0] OPEN_TICKS_RST   = 16'd5000;
  localparam logic [TICK_W-1:0] IDLE_TICKS_RST   = 16'd10000;
  localparam logic [TICK_W-1:0] TICK_MAX         = 16'hFFFF;

  // Request kinds
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_PRESS = 1'b1;

  localparam logic [1:0] BTN_LEARN  = 2'd2;
  localparam logic [1:0] BTN_UNUSED = 2'd3;
  localparam logic [1:0] DIGIT_LEARN = 2'd3;

  localparam int unsigned INIT_LEN = 8;
  localparam logic [1:0] CODE_INIT [INIT_LEN] = '{
    2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd0
  };

  typedef struct packed {
    logic       cmd;
    logic [1:0] button;
    logic       hold_level;
  } in_item_t;

  typedef struct packed {
    logic       locked;
    logic       learning;
    logic       opened;
    logic       code_stored;
    logic       key_accepted;
    logic [1:0] key_digit;
  } out_item_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] digit;
  } key_t;

  function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
    return (v == TICK_MAX) ? v : v + 1'b1;
  endfunction

  // Reset code; positions past the built-in code read as 0
  function automatic logic [1:0] init_digit(input int unsigned i);
    return (i < INIT_LEN) ? CODE_INIT[i] : 2'd0;
  endfunction

  function automatic logic [1:0] btn_digit(input logic [1:0] btn);
    return (btn == BTN_LEARN) ? DIGIT_LEARN : btn;
  endfunction

endpackage

/* design/clc_key_filter.sv */
// Per-button debounce and learn-switch hold timer; turns requests into digits.
module clc_key_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  clc_pkg::in_item_t              item,
  input  logic [clc_pkg::TICK_W-1:0]     filter_ticks,
  input  logic [clc_pkg::TICK_W-1:0]     hold_ticks,
  output clc_pkg::key_t                  key
);
  import clc_pkg::*;

  logic [NUM_BTN-1:0] seen_r, seen_nxt;
  logic [TICK_W-1:0]  elapsed_r [NUM_BTN];
  logic [TICK_W-1:0]  elapsed_nxt [NUM_BTN];
  logic [TICK_W-1:0]  hold_cnt_r, hold_cnt_nxt;
  logic [TICK_W-1:0]  hold_inc;

  assign hold_inc = sat_inc(hold_cnt_r);

  always_comb begin
    key          = '0;
    seen_nxt     = seen_r;
    elapsed_nxt  = elapsed_r;
    hold_cnt_nxt = hold_cnt_r;
    if (item.cmd == CMD_TICK) begin
      for (int b = 0; b < NUM_BTN; b++) begin
        elapsed_nxt[b] = sat_inc(elapsed_r[b]);
      end
      if (item.hold_level) begin
        if (hold_inc > hold_ticks) begin
          hold_cnt_nxt = '0;
          key.accepted = 1'b1;
          key.digit    = DIGIT_LEARN;
        end else begin
          hold_cnt_nxt = hold_inc;
        end
      end else begin
        hold_cnt_nxt = '0;
      end
    end else begin
      // the unused button code matches no entry and is dropped
      for (int b = 0; b < NUM_BTN; b++) begin
        if (item.button == 2'(b) && (!seen_r[b] || elapsed_r[b] > filter_ticks)) begin
          seen_nxt[b]    = 1'b1;
          elapsed_nxt[b] = '0;
          key.accepted   = 1'b1;
          key.digit      = btn_digit(item.button);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      hold_cnt_r <= '0;
      for (int b = 0; b < NUM_BTN; b++) begin
        elapsed_r[b] <= '0;
      end
    end else if (fire) begin
      seen_r     <= seen_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      elapsed_r  <= elapsed_nxt;
    end
  end

endmodule

/* design/code_lock_controller.sv */
// Door code lock: top level with request stage, lock state and result register.
//
// Usage:
//   in_*   : one request per handshake, either a tick (cmd 0, with hold_level)
//            or a button press (cmd 1, button 0..2; button 3 is ignored).
//   out_*  : exactly one result per request, in request order: lock and mode
//            status after the request plus opened / code_stored / key pulses.
//   cfg_*  : register writes (index 0 filter, 1 hold, 2 open, 3 idle ticks),
//            always ready; write only while no request is in flight.
// Path: request register first, then the result register, which drives out_*.
// Throughput: one request per cycle while out_ready is high; the request
//   register feeds lock logic and result register; both advance in the same cycle.
// Out stall: the result register holds its value; the request register still
//   takes one more request, then in_ready drops until out_ready returns.
// Reset (synchronous, rst_n low): door locked, normal mode, default code
//   1,1,1,1,0,1,1,0, history and timers cleared, registers at defaults.
module code_lock_controller #(
  parameter int unsigned CODE_LEN = clc_pkg::CODE_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  clc_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output clc_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [clc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clc_pkg::TICK_W-1:0]      cfg_data
);
  import clc_pkg::*;

  localparam int unsigned CNT_W = $clog2(CODE_LEN + 1);
  localparam logic [CNT_W-1:0] LEN_C = CNT_W'(CODE_LEN);

  logic [TICK_W-1:0] filter_ticks_r, hold_ticks_r, open_ticks_r, idle_ticks_r;

  in_item_t  stg_r;
  logic      stg_valid_r;
  out_item_t out_r;
  logic      out_valid_r;
  logic      adv;
  key_t      key;

  logic              learning_r, learning_nxt;
  logic              locked_r, locked_nxt;
  logic [1:0]        code_r [CODE_LEN];
  logic [1:0]        code_nxt [CODE_LEN];
  logic [1:0]        hist_r [CODE_LEN];
  logic [1:0]        hist_nxt [CODE_LEN];
  logic [CNT_W-1:0]  pos_r, pos_nxt, pos_inc;
  logic [CNT_W-1:0]  hcnt_r, hcnt_nxt;
  logic [TICK_W-1:0] idle_r, idle_nxt, idle_inc;
  logic [TICK_W-1:0] open_r, open_nxt, open_inc;
  logic              opened, stored, match;
  out_item_t         res;

  // ---------------- handshake ----------------
  assign adv       = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !stg_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        stg_valid_r <= 1'b1;
      end else if (adv) begin
        stg_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_r <= in_data;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_ticks_r <= FILTER_TICKS_RST;
      hold_ticks_r   <= HOLD_TICKS_RST;
      open_ticks_r   <= OPEN_TICKS_RST;
      idle_ticks_r   <= IDLE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FILTER_TICKS: filter_ticks_r <= cfg_data;
        REG_HOLD_TICKS:   hold_ticks_r   <= cfg_data;
        REG_OPEN_TICKS:   open_ticks_r   <= cfg_data;
        REG_IDLE_TICKS:   idle_ticks_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- digit source ----------------
  clc_key_filter u_key_filter (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (adv),
    .item         (stg_r),
    .filter_ticks (filter_ticks_r),
    .hold_ticks   (hold_ticks_r),
    .key          (key)
  );

  // ---------------- lock logic ----------------
  assign idle_inc = sat_inc(idle_r);
  assign open_inc = sat_inc(open_r);
  assign pos_inc  = pos_r + 1'b1;

  always_comb begin
    learning_nxt = learning_r;
    locked_nxt   = locked_r;
    code_nxt     = code_r;
    hist_nxt     = hist_r;
    pos_nxt      = pos_r;
    hcnt_nxt     = hcnt_r;
    idle_nxt     = idle_r;
    open_nxt     = open_r;
    opened       = 1'b0;
    stored       = 1'b0;
    match        = 1'b1;

    if (stg_r.cmd == CMD_TICK) begin
      // the open timer pauses while learning; the idle timer counts but does not clear history
      if (!learning_r && !locked_r) begin
        if (open_inc > open_ticks_r) begin
          locked_nxt = 1'b1;
          open_nxt   = '0;
        end else begin
          open_nxt = open_inc;
        end
      end
      idle_nxt = idle_inc;
      if (!learning_r && idle_inc >= idle_ticks_r) begin
        hcnt_nxt = '0;
      end
    end else if (stg_r.button != BTN_UNUSED) begin
      idle_nxt = '0;
    end

    if (key.accepted) begin
      if (learning_r) begin
        for (int i = 0; i < CODE_LEN; i++) begin
          if (pos_r == CNT_W'(i)) begin
            code_nxt[i] = key.digit;
          end
        end
        if (pos_inc >= LEN_C) begin
          learning_nxt = 1'b0;
          pos_nxt      = '0;
          stored       = 1'b1;
        end else begin
          pos_nxt = pos_inc;
        end
      end else if (key.digit == DIGIT_LEARN) begin
        learning_nxt = 1'b1;
        pos_nxt      = '0;
        hcnt_nxt     = '0;
      end else begin
        for (int i = 0; i + 1 < CODE_LEN; i++) begin
          hist_nxt[i] = hist_r[i + 1];
        end
        hist_nxt[CODE_LEN-1] = key.digit;
        if (hcnt_nxt < LEN_C) begin
          hcnt_nxt = hcnt_nxt + 1'b1;
        end
        for (int i = 0; i < CODE_LEN; i++) begin
          if (hist_nxt[i] != code_r[i]) begin
            match = 1'b0;
          end
        end
        if (hcnt_nxt >= LEN_C && match) begin
          locked_nxt = 1'b0;
          hcnt_nxt   = '0;
          opened     = 1'b1;
        end
      end
    end

    res.locked       = locked_nxt;
    res.learning     = learning_nxt;
    res.opened       = opened;
    res.code_stored  = stored;
    res.key_accepted = key.accepted;
    res.key_digit    = key.digit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learning_r <= 1'b0;
      locked_r   <= 1'b1;
      pos_r      <= '0;
      hcnt_r     <= '0;
      idle_r     <= '0;
      open_r     <= '0;
      for (int i = 0; i < CODE_LEN; i++) begin
        code_r[i] <= init_digit(i);
        hist_r[i] <= '0;
      end
    end else if (adv) begin
      learning_r <= learning_nxt;
      locked_r   <= locked_nxt;
      pos_r      <= pos_nxt;
      hcnt_r     <= hcnt_nxt;
      idle_r     <= idle_nxt;
      open_r     <= open_nxt;
      code_r     <= code_nxt;
      hist_r     <= hist_nxt;
    end
  end

endmodule

/* design/clc_checker.sv */
// Port-level checks for the code lock controller, bound to the top level.
`include "code_lock_controller_defines.svh"

module clc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input clc_pkg::out_item_t out_data
);
  import clc_pkg::*;

  // a stalled result stays put
  `CLC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // a match opens the door from normal mode on an accepted digit
  `CLC_ASSERT_NOW(a_open_state, clk, rst_n, out_valid && out_data.opened, !out_data.locked && !out_data.learning && out_data.key_accepted)

  // storing a code ends learning and needs a digit
  `CLC_ASSERT_NOW(a_store_state, clk, rst_n, out_valid && out_data.code_stored, !out_data.learning && out_data.key_accepted && !out_data.opened)

  // no digit value without an accepted key
  `CLC_ASSERT_NOW(a_digit_zero, clk, rst_n, out_valid && !out_data.key_accepted, out_data.key_digit == 2'd0)

endmodule

bind code_lock_controller clc_checker u_clc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* sim/code_lock_controller_test.sv */
// Self-checking testbench for the door code lock: predictor, request driver and result checker.
`timescale 1ns / 100ps

module code_lock_controller_test;
  import clc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int KEYS         = CODE_LEN_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_OFF_LEN = 60;

  localparam logic [1:0] BTN_ZERO = 2'd0;
  localparam logic [1:0] BTN_ONE  = 2'd1;
  localparam logic [1:0] FACTORY_CODE [8] = '{2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0] cfg_data = '0;

  code_lock_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Lock model state
  logic [15:0] filter_lim, hold_lim, open_lim, idle_lim;
  logic learn_mode, door_shut;
  logic [KEYS-1:0][1:0] code_digits, recent_keys;
  int learn_pos, recent_cnt;
  logic [15:0] idle_cnt, open_cnt, hold_cnt;
  logic btn_seen [NUM_BTN];
  logic [15:0] btn_age [NUM_BTN];

  out_item_t lock_results [$];
  int err_count = 0;
  int cycle_count = 0;

  // Stimulus-side knobs
  int reqs_sent = 0;
  int sender_gap_pct = 0;
  int sink_stall_pct = 0;
  int cur_filter = 200;
  int cur_hold = 3000;
  int hold_offs_asked = 0;
  int hold_offs_served = 0;
  int hold_off_left = 0;

  function automatic logic [15:0] sat_bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void reset_lock_model();
    int k;
    filter_lim = FILTER_TICKS_RST;
    hold_lim   = HOLD_TICKS_RST;
    open_lim   = OPEN_TICKS_RST;
    idle_lim   = IDLE_TICKS_RST;
    learn_mode = 1'b0;
    door_shut  = 1'b1;
    for (k = 0; k < KEYS; k++) begin
      code_digits[k] = (k < 8) ? FACTORY_CODE[k] : 2'd0;
    end
    recent_keys = '0;
    learn_pos   = 0;
    recent_cnt  = 0;
    idle_cnt    = '0;
    open_cnt    = '0;
    hold_cnt    = '0;
    for (k = 0; k < NUM_BTN; k++) begin
      btn_seen[k] = 1'b0;
      btn_age[k]  = '0;
    end
  endfunction

  function automatic out_item_t predict_lock(input in_item_t req);
    out_item_t res;
    logic got_key;
    logic [1:0] key;
    int k;
    res = '0;
    got_key = 1'b0;
    key = 2'd0;
    if (req.cmd == CMD_TICK) begin
      for (k = 0; k < NUM_BTN; k++) btn_age[k] = sat_bump(btn_age[k]);
      if (!learn_mode && !door_shut) begin
        open_cnt = sat_bump(open_cnt);
        if (open_cnt > open_lim) begin
          door_shut = 1'b1;
          open_cnt = '0;
        end
      end
      idle_cnt = sat_bump(idle_cnt);
      if (!learn_mode && idle_cnt >= idle_lim) recent_cnt = 0;
      if (req.hold_level) begin
        hold_cnt = sat_bump(hold_cnt);
        if (hold_cnt > hold_lim) begin
          hold_cnt = '0;
          got_key = 1'b1;
          key = DIGIT_LEARN;
        end
      end else begin
        hold_cnt = '0;
      end
    end else if (req.button != BTN_UNUSED) begin
      idle_cnt = '0;
      if (!btn_seen[req.button] || btn_age[req.button] > filter_lim) begin
        btn_seen[req.button] = 1'b1;
        btn_age[req.button] = '0;
        got_key = 1'b1;
        key = (req.button == BTN_LEARN) ? DIGIT_LEARN : req.button;
      end
    end

    if (got_key) begin
      if (learn_mode) begin
        if (learn_pos < KEYS) code_digits[learn_pos] = key;
        learn_pos++;
        if (learn_pos >= KEYS) begin
          learn_mode = 1'b0;
          learn_pos = 0;
          res.code_stored = 1'b1;
        end
      end else if (key == DIGIT_LEARN) begin
        learn_mode = 1'b1;
        learn_pos = 0;
        recent_cnt = 0;
      end else begin
        for (k = 0; k < KEYS - 1; k++) recent_keys[k] = recent_keys[k + 1];
        recent_keys[KEYS - 1] = key;
        if (recent_cnt < KEYS) recent_cnt++;
        if (recent_cnt >= KEYS && recent_keys == code_digits) begin
          door_shut = 1'b0;
          recent_cnt = 0;
          res.opened = 1'b1;
        end
      end
    end

    res.locked = door_shut;
    res.learning = learn_mode;
    res.key_accepted = got_key;
    res.key_digit = key;
    return res;
  endfunction

  // Predictor: follows register writes and every accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_lock_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FILTER_TICKS: filter_lim = cfg_data;
          REG_HOLD_TICKS:   hold_lim = cfg_data;
          REG_OPEN_TICKS:   open_lim = cfg_data;
          REG_IDLE_TICKS:   idle_lim = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        lock_results.insert(lock_results.size(), predict_lock(in_data));
      end
    end
  end

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (lock_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $time, out_data);
        err_count++;
      end else begin
        want = lock_results.pop_front();
        check_field("locked", want.locked, out_data.locked);
        check_field("learning", want.learning, out_data.learning);
        check_field("opened", want.opened, out_data.opened);
        check_field("code_stored", want.code_stored, out_data.code_stored);
        check_field("key_accepted", want.key_accepted, out_data.key_accepted);
        check_field("key_digit", want.key_digit, out_data.key_digit);
      end
    end
  end

  // Result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_offs_served != hold_offs_asked) begin
      hold_offs_served <= hold_offs_asked;
      hold_off_left <= HOLD_OFF_LEN;
      out_ready <= 1'b0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d results pending", $time, lock_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_req(input logic c, input logic [1:0] b, input logic h);
    in_item_t req;
    req.cmd = c;
    req.button = b;
    req.hold_level = h;
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!(c == CMD_PRESS && b == BTN_UNUSED)) reqs_sent++;
  endtask

  task automatic settle_lock();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lock_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_timers(input int f, input int h, input int o, input int i);
    settle_lock();
    put_reg(REG_FILTER_TICKS, f[15:0]);
    put_reg(REG_HOLD_TICKS, h[15:0]);
    put_reg(REG_OPEN_TICKS, o[15:0]);
    put_reg(REG_IDLE_TICKS, i[15:0]);
    cfg_valid <= 1'b0;
    cur_filter = f;
    cur_hold = h;
  endtask

  // Ticks first so the debounce gap of that button has passed
  task automatic press_digit(input logic [1:0] d);
    repeat (cur_filter + 1) send_req(CMD_TICK, 2'($urandom_range(3)), 1'b0);
    send_req(CMD_PRESS, (d == DIGIT_LEARN) ? BTN_LEARN : d, 1'($urandom_range(1)));
  endtask

  task automatic try_code();
    logic [KEYS-1:0][1:0] attempt;
    int k;
    // a plain tick cannot touch the code, so the copy below is settled
    send_req(CMD_TICK, 2'($urandom_range(3)), 1'b0);
    attempt = code_digits;
    if ($urandom_range(3) == 0) attempt[$urandom_range(KEYS - 1)] = 2'($urandom_range(1));
    for (k = 0; k < KEYS; k++) press_digit(attempt[k]);
  endtask

  task automatic teach_code();
    int k;
    send_req(CMD_TICK, BTN_ZERO, 1'b0);
    if (cur_hold < 16 && $urandom_range(1) == 1) begin
      repeat (cur_hold + 1) send_req(CMD_TICK, 2'($urandom_range(3)), 1'b1);
    end else begin
      press_digit(DIGIT_LEARN);
    end
    for (k = 0; k < KEYS; k++) begin
      press_digit(($urandom_range(15) == 0) ? DIGIT_LEARN : 2'($urandom_range(1)));
    end
  endtask

  task automatic tick_run();
    repeat ($urandom_range(1, 40)) begin
      send_req(CMD_TICK, 2'($urandom_range(3)), ($urandom_range(9) == 0));
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(2, 8)) begin
      send_req(1'($urandom_range(1)), 2'($urandom_range(3)), 1'($urandom_range(1)));
    end
  endtask

  task automatic run_lock_traffic(input int n);
    int goal;
    int pick;
    goal = reqs_sent + n;
    while (reqs_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 35) try_code();
      else if (pick < 60) teach_code();
      else if (pick < 80) tick_run();
      else noise_burst();
    end
  endtask

  // Reset timers: first presses pass, repeats are filtered, button 3 does nothing
  task automatic check_reset_defaults();
    send_req(CMD_PRESS, BTN_ZERO, 1'b1);
    send_req(CMD_PRESS, BTN_ZERO, 1'b0);
    send_req(CMD_PRESS, BTN_UNUSED, 1'b0);
    send_req(CMD_PRESS, BTN_ONE, 1'b0);
    send_req(CMD_TICK, BTN_UNUSED, 1'b1);
    send_req(CMD_TICK, BTN_ZERO, 1'b0);
    send_req(CMD_PRESS, BTN_LEARN, 1'b0);
  endtask

  // Limits at the ends of their range: learn digits from the hold switch,
  // debounce that never reopens, idle clearing held off while learning
  task automatic check_timer_extremes();
    set_timers(65535, 0, 0, 0);
    send_req(CMD_TICK, BTN_ONE, 1'b1);
    send_req(CMD_TICK, BTN_LEARN, 1'b1);
    send_req(CMD_PRESS, BTN_ZERO, 1'b0);
    send_req(CMD_PRESS, BTN_ONE, 1'b1);
    send_req(CMD_PRESS, BTN_UNUSED, 1'b1);
    send_req(CMD_TICK, BTN_UNUSED, 1'b0);
    send_req(CMD_PRESS, BTN_LEARN, 1'b0);
  endtask

  // Door never relocks here, so repeated matches land on an open door
  task automatic check_no_idle();
    set_timers(0, 3, 65535, 65535);
    sender_gap_pct = 0;
    sink_stall_pct <= 0;
    run_lock_traffic(105);
  endtask

  task automatic check_sender_gaps();
    set_timers(1, 65535, 6, 5);
    sender_gap_pct = 70;
    sink_stall_pct <= 0;
    run_lock_traffic(105);
  endtask

  task automatic check_receiver_stalls();
    set_timers(2, 1, 12, $urandom_range(4, 40));
    sender_gap_pct = 0;
    sink_stall_pct <= 70;
    run_lock_traffic(105);
  endtask

  task automatic check_both_idle();
    int f;
    f = $urandom_range(0, 2);
    set_timers(f, $urandom_range(0, 8), $urandom_range(0, 30), $urandom_range(f + 2, 60));
    sender_gap_pct = 23;
    sink_stall_pct <= 23;
    run_lock_traffic(105);
  endtask

  // Receiver holds off while requests keep coming, so the input side backs up
  task automatic check_backpressure();
    sender_gap_pct = 0;
    sink_stall_pct <= 0;
    hold_offs_asked <= hold_offs_asked + 1;
    run_lock_traffic(25);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    check_reset_defaults();
    check_timer_extremes();
    check_no_idle();
    check_sender_gaps();
    check_receiver_stalls();
    check_both_idle();
    check_backpressure();
    settle_lock();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
